[hdl/bwjm_pkg.sv]
package bwjm_pkg;

  localparam int unsigned HoldW = 10;
  localparam int unsigned DeflW = 15;
  localparam int unsigned StickW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 15;

  typedef logic signed [StickW-1:0] q14_t;

  localparam q14_t QOne = 16'sd16384;
  localparam q14_t QNegOne = -16'sd16384;
  localparam q14_t QZero = 16'sd0;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HOLD_FRAMES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_DEFL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEFL_STEP = 2'd2;

  localparam logic [HoldW-1:0] HoldFramesRst = 10'd20;
  localparam logic [DeflW-1:0] FirstDeflRst = 15'd8192;
  localparam logic [DeflW-1:0] DeflStepRst = 15'd1638;

  // event codes
  localparam logic [3:0] EV_L_TRIG_DN = 4'd0;
  localparam logic [3:0] EV_L_TRIG_UP = 4'd1;
  localparam logic [3:0] EV_L_GRIP_DN = 4'd2;
  localparam logic [3:0] EV_L_GRIP_UP = 4'd3;
  localparam logic [3:0] EV_L_WHEEL_UP = 4'd4;
  localparam logic [3:0] EV_L_WHEEL_DN = 4'd5;
  localparam logic [3:0] EV_R_GRIP_DN = 4'd6;
  localparam logic [3:0] EV_R_GRIP_UP = 4'd7;
  localparam logic [3:0] EV_R_TRIG_DN = 4'd8;
  localparam logic [3:0] EV_R_TRIG_UP = 4'd9;
  localparam logic [3:0] EV_R_WHEEL_UP = 4'd10;
  localparam logic [3:0] EV_R_WHEEL_DN = 4'd11;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_BUTTON,
    OP_WHEEL_UP,
    OP_WHEEL_DN
  } side_op_e;

  typedef struct packed {
    side_op_e op;
    logic     grip;
    q14_t     y;
  } side_cmd_t;

  typedef struct packed {
    logic             grip;
    q14_t             x;
    q14_t             y;
    logic [HoldW-1:0] up_cnt;
    logic [HoldW-1:0] dn_cnt;
  } side_state_t;

  typedef struct packed {
    logic [HoldW-1:0] hold_frames;
    logic [DeflW-1:0] first_defl;
    logic [DeflW-1:0] defl_step;
  } cfg_t;

endpackage

[hdl/bwjm_if.sv]
interface bwjm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] event_code;

  modport source (output valid, output kind, output event_code, input ready);
  modport sink (input valid, input kind, input event_code, output ready);
endinterface

interface bwjm_out_if;
  logic               valid;
  logic               ready;
  logic               left_grip;
  logic signed [15:0] left_stick_x;
  logic signed [15:0] left_stick_y;
  logic               right_grip;
  logic signed [15:0] right_stick_x;
  logic signed [15:0] right_stick_y;

  modport source (
    output valid, output left_grip, output left_stick_x, output left_stick_y,
    output right_grip, output right_stick_x, output right_stick_y, input ready
  );
  modport sink (
    input valid, input left_grip, input left_stick_x, input left_stick_y,
    input right_grip, input right_stick_x, input right_stick_y, output ready
  );
endinterface

interface bwjm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/bwjm_side.sv]
module bwjm_side import bwjm_pkg::*; (
  input  cfg_t        cfg_i,
  input  side_cmd_t   cmd_i,
  input  side_state_t cur_i,
  output side_state_t nxt_o
);

  logic signed [StickW+1:0] x_wide;
  logic signed [StickW+1:0] ext_wide;
  logic signed [StickW+1:0] stp_wide;
  logic signed [StickW+1:0] x_sum;
  side_state_t              nxt;

  assign x_wide = {{2{cur_i.x[StickW-1]}}, cur_i.x};
  assign ext_wide = $signed({3'b000, cfg_i.first_defl});
  assign stp_wide = $signed({3'b000, cfg_i.defl_step});

  // candidate x for a wheel event, before saturation
  always_comb begin
    x_sum = x_wide;
    if (cmd_i.op == OP_WHEEL_UP) begin
      if (cur_i.x == QZero) begin
        x_sum = ext_wide;
      end else if (cur_i.x > QZero) begin
        x_sum = x_wide + stp_wide;
      end
    end else if (cmd_i.op == OP_WHEEL_DN) begin
      if (cur_i.x == QZero) begin
        x_sum = -ext_wide;
      end else if (cur_i.x < QZero) begin
        x_sum = x_wide - stp_wide;
      end
    end
  end

  always_comb begin
    nxt = cur_i;
    unique case (cmd_i.op)
      OP_BUTTON: begin
        nxt.grip = cmd_i.grip;
        nxt.y = cmd_i.y;
      end
      OP_WHEEL_UP: begin
        nxt.grip = 1'b1;
        nxt.x = (x_sum > 18'sd16384) ? QOne : x_sum[StickW-1:0];
        nxt.up_cnt = cfg_i.hold_frames;
      end
      OP_WHEEL_DN: begin
        nxt.grip = 1'b1;
        nxt.x = (x_sum < -18'sd16384) ? QNegOne : x_sum[StickW-1:0];
        nxt.dn_cnt = cfg_i.hold_frames;
      end
      default: begin
      end
    endcase

    // hold counters: only one may run, otherwise both clear and x centers
    if (nxt.up_cnt != '0 && nxt.dn_cnt == '0) begin
      nxt.up_cnt = nxt.up_cnt - 1'b1;
      if (nxt.up_cnt == '0) begin
        nxt.grip = 1'b0;
        nxt.x = QZero;
      end
    end else if (nxt.dn_cnt != '0 && nxt.up_cnt == '0) begin
      nxt.dn_cnt = nxt.dn_cnt - 1'b1;
      if (nxt.dn_cnt == '0) begin
        nxt.grip = 1'b0;
        nxt.x = QZero;
      end
    end else begin
      nxt.up_cnt = '0;
      nxt.dn_cnt = '0;
      nxt.x = QZero;
    end
  end

  assign nxt_o = nxt;

endmodule

[hdl/button_wheel_to_joystick_mapper.sv]
// path: a frame is captured in the input register at the transaction edge, then in the
// side state registers when the output is free; these also serve as the result register
// throughput: one frame per cycle unless result_o stalls; each side updates combinationally
// reset: both sides cleared (grip released, sticks centered, hold counters zero),
// configuration registers back to 20 frames, 0.5 and 0.1 deflection
module button_wheel_to_joystick_mapper import bwjm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  bwjm_in_if.sink   frame_i,
  bwjm_cfg_if.sink  cfg_i,
  bwjm_out_if.source result_o
);

  cfg_t        cfg_q;
  logic        in_vld_q;
  logic        kind_q;
  logic [3:0]  code_q;
  logic        out_vld_q;
  logic        advance;
  side_cmd_t   cmd_l;
  side_cmd_t   cmd_r;
  side_state_t left_q;
  side_state_t left_d;
  side_state_t right_q;
  side_state_t right_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_frames <= HoldFramesRst;
      cfg_q.first_defl <= FirstDeflRst;
      cfg_q.defl_step <= DeflStepRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_HOLD_FRAMES: cfg_q.hold_frames <= cfg_i.data[HoldW-1:0];
        CFG_FIRST_DEFL:  cfg_q.first_defl <= cfg_i.data[DeflW-1:0];
        CFG_DEFL_STEP:   cfg_q.defl_step <= cfg_i.data[DeflW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input stage, result stage is the side state
  assign advance = in_vld_q && (!out_vld_q || result_o.ready);
  assign frame_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (frame_i.ready) begin
      in_vld_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid && frame_i.ready) begin
      kind_q <= frame_i.kind;
      code_q <= frame_i.event_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // event decode into one command per side
  always_comb begin
    cmd_l = '{op: OP_NONE, grip: 1'b0, y: QZero};
    cmd_r = '{op: OP_NONE, grip: 1'b0, y: QZero};
    if (kind_q) begin
      unique case (code_q)
        EV_L_TRIG_DN:  cmd_l = '{op: OP_BUTTON, grip: 1'b1, y: QOne};
        EV_L_TRIG_UP:  cmd_l = '{op: OP_BUTTON, grip: 1'b0, y: QZero};
        EV_L_GRIP_DN:  cmd_l = '{op: OP_BUTTON, grip: 1'b1, y: QNegOne};
        EV_L_GRIP_UP:  cmd_l = '{op: OP_BUTTON, grip: 1'b0, y: QZero};
        EV_L_WHEEL_UP: cmd_l.op = OP_WHEEL_UP;
        EV_L_WHEEL_DN: cmd_l.op = OP_WHEEL_DN;
        EV_R_GRIP_DN:  cmd_r = '{op: OP_BUTTON, grip: 1'b1, y: QNegOne};
        EV_R_GRIP_UP:  cmd_r = '{op: OP_BUTTON, grip: 1'b0, y: QZero};
        EV_R_TRIG_DN:  cmd_r = '{op: OP_BUTTON, grip: 1'b1, y: QOne};
        EV_R_TRIG_UP:  cmd_r = '{op: OP_BUTTON, grip: 1'b0, y: QZero};
        EV_R_WHEEL_UP: cmd_r.op = OP_WHEEL_UP;
        EV_R_WHEEL_DN: cmd_r.op = OP_WHEEL_DN;
        default: begin
        end
      endcase
    end
  end

  bwjm_side u_left (
    .cfg_i (cfg_q),
    .cmd_i (cmd_l),
    .cur_i (left_q),
    .nxt_o (left_d)
  );

  bwjm_side u_right (
    .cfg_i (cfg_q),
    .cmd_i (cmd_r),
    .cur_i (right_q),
    .nxt_o (right_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      right_q <= '0;
    end else if (advance) begin
      left_q <= left_d;
      right_q <= right_d;
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.left_grip = left_q.grip;
  assign result_o.left_stick_x = left_q.x;
  assign result_o.left_stick_y = left_q.y;
  assign result_o.right_grip = right_q.grip;
  assign result_o.right_stick_x = right_q.x;
  assign result_o.right_stick_y = right_q.y;

`ifndef ASSERT_OFF
  a_left_cnt_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(left_q.up_cnt != '0 && left_q.dn_cnt != '0))
    else $error("left hold counters both active");

  a_right_cnt_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(right_q.up_cnt != '0 && right_q.dn_cnt != '0))
    else $error("right hold counters both active");

  a_left_x_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q.x != QZero |-> (left_q.up_cnt != '0 || left_q.dn_cnt != '0))
    else $error("left stick x deflected without a running counter");

  a_right_x_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_q.x != QZero |-> (right_q.up_cnt != '0 || right_q.dn_cnt != '0))
    else $error("right stick x deflected without a running counter");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q.x <= QOne && left_q.x >= QNegOne && right_q.x <= QOne && right_q.x >= QNegOne)
    else $error("stick x out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(left_q) && $stable(right_q))
    else $error("side state changed without a frame");
`endif

endmodule
